>>> sv/lav_pkg.sv
// lav_pkg: widths, latencies and packed vector types for the look-at view matrix
// no dependencies; compiled first
package lav_pkg;

	// Q16.16 basics
	localparam int FRAC  = 16;
	localparam int EYE_W = 32;

	// normalizer datapath
	localparam int NIN_W   = 36;           // signed input components
	localparam int NOUT_W  = 18;           // signed unit components, |v| <= 1.0
	localparam int MAG_W   = NIN_W;
	localparam int M_W     = 30;           // scaled magnitudes, the largest in [2^29, 2^30)
	localparam int POS_W   = $clog2(MAG_W);
	localparam int SQ_W    = 63;           // sum of squares and root registers
	localparam int LEN_W   = 31;
	localparam int NUM_W   = 48;           // dividend and remainder
	localparam int Q_W     = 17;           // quotient, up to 1.0
	localparam int SQ_ITER = 31;
	localparam int SQ_PER  = 2;
	localparam int SQ_STG  = (SQ_ITER + SQ_PER - 1) / SQ_PER;
	localparam int DIV_PER = 2;
	localparam int DIV_STG = (Q_W + DIV_PER - 1) / DIV_PER;
	// magnitude, position, shift, square, root stages, divide stages, output
	localparam int NORM_LAT = 4 + (SQ_STG + 1) + (DIV_STG + 1) + 1;

	localparam logic [Q_W-1:0] Q_ONE = Q_W'(65536);
	localparam logic signed [EYE_W-1:0] ONE_Q16 = 32'sd65536;
	localparam logic [1:0] LAST_COL = 2'd3;

	typedef logic [2:0][EYE_W-1:0]  eye3_t;
	typedef logic [2:0][NIN_W-1:0]  nvin_t;
	typedef logic [2:0][NOUT_W-1:0] nvout_t;

endpackage

>>> sv/lav_if.sv
// lav_if: valid/ready channel interfaces for camera input and matrix column output
// no dependencies
interface lav_cam_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] eye_x;
	logic signed [31:0] eye_y;
	logic signed [31:0] eye_z;
	logic signed [31:0] target_x;
	logic signed [31:0] target_y;
	logic signed [31:0] target_z;
	logic signed [31:0] up_x;
	logic signed [31:0] up_y;
	logic signed [31:0] up_z;

	modport source (output valid, eye_x, eye_y, eye_z, target_x, target_y, target_z,
		up_x, up_y, up_z, input ready);
	modport sink (input valid, eye_x, eye_y, eye_z, target_x, target_y, target_z,
		up_x, up_y, up_z, output ready);
endinterface

interface lav_col_if;
	logic               valid;
	logic               ready;
	logic        [1:0]  column_index;
	logic signed [31:0] entry_row0;
	logic signed [31:0] entry_row1;
	logic signed [31:0] entry_row2;
	logic signed [31:0] entry_row3;
	logic               last_column;
	logic               degenerate;
	logic               saturated;

	modport source (output valid, column_index, entry_row0, entry_row1, entry_row2,
		entry_row3, last_column, degenerate, saturated, input ready);
	modport sink (input valid, column_index, entry_row0, entry_row1, entry_row2,
		entry_row3, last_column, degenerate, saturated, output ready);
endinterface

>>> sv/lav_norm.sv
// lav_norm: pipelined 3-vector normalizer, magnitude scaling, square root and divide
// depends on lav_pkg; advances only when en is high
module lav_norm (
	input  logic           clk,
	input  logic           en,
	input  lav_pkg::nvin_t vin,
	output lav_pkg::nvout_t vout,
	output logic           zero
);
	import lav_pkg::*;

	typedef struct packed {
		logic [2:0][M_W-1:0] m;
		logic [2:0]          neg;
		logic                zero;
	} sq_side_t;

	typedef struct packed {
		logic [LEN_W-1:0] len;
		logic [2:0]       neg;
		logic             zero;
	} dv_side_t;

	localparam logic [POS_W-1:0] TOP_POS = POS_W'(M_W - 1);

	// magnitudes and maximum
	logic [2:0][MAG_W-1:0] mag_c;
	logic [MAG_W-1:0]      mx_c;
	logic [2:0][MAG_W-1:0] mag_s1, mag_s2;
	logic [MAG_W-1:0]      mx_s1;
	logic [2:0]            neg_s1, neg_s2, neg_s3, neg_s4;
	logic [POS_W-1:0]      pos_c, pos_s2;
	logic                  zero_s2, zero_s3, zero_s4;
	logic [2:0][M_W-1:0]   m_c, m_s3, m_s4;
	logic [2:0][2*M_W-1:0] sq_s4;

	always_comb begin
		for (int i = 0; i < 3; i++)
			mag_c[i] = vin[i][NIN_W-1] ? (~vin[i] + 1'b1) : vin[i];
		mx_c = mag_c[0];
		if (mag_c[1] > mx_c) mx_c = mag_c[1];
		if (mag_c[2] > mx_c) mx_c = mag_c[2];
	end

	// position of the leading one
	always_comb begin
		pos_c = '0;
		for (int b = 0; b < MAG_W; b++)
			if (mx_s1[b]) pos_c = POS_W'(b);
	end

	// bring the largest magnitude into [2^29, 2^30)
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (pos_s2 < TOP_POS)
				m_c[i] = M_W'(mag_s2[i] << (TOP_POS - pos_s2));
			else
				m_c[i] = M_W'(mag_s2[i] >> (pos_s2 - TOP_POS));
		end
	end

	// square root stages, index 0 holds the sum of squares
	logic [SQ_W-1:0] sq_rem_s [SQ_STG+1];
	logic [SQ_W-1:0] sq_res_s [SQ_STG+1];
	sq_side_t        sq_sd_s  [SQ_STG+1];
	logic [SQ_W-1:0] sq_rem_n [SQ_STG+1];
	logic [SQ_W-1:0] sq_res_n [SQ_STG+1];

	always_comb begin
		logic [SQ_W-1:0] r, q, t, b;
		int it;
		sq_rem_n[0] = '0;
		sq_res_n[0] = '0;
		for (int k = 1; k <= SQ_STG; k++) begin
			r = sq_rem_s[k-1];
			q = sq_res_s[k-1];
			for (int j = 0; j < SQ_PER; j++) begin
				it = (k - 1) * SQ_PER + j;
				if (it < SQ_ITER) begin
					b = SQ_W'(1) << (2 * (SQ_ITER - 1 - it));
					t = q + b;
					if (r >= t) begin
						r = r - t;
						q = (q >> 1) + b;
					end else begin
						q = q >> 1;
					end
				end
			end
			sq_rem_n[k] = r;
			sq_res_n[k] = q;
		end
	end

	// divide stages, index 0 forms the rounded dividend
	logic [2:0][NUM_W-1:0] dv_rem_s [DIV_STG+1];
	logic [2:0][Q_W-1:0]   dv_q_s   [DIV_STG+1];
	dv_side_t              dv_sd_s  [DIV_STG+1];
	logic [2:0][NUM_W-1:0] dv_rem_n [DIV_STG+1];
	logic [2:0][Q_W-1:0]   dv_q_n   [DIV_STG+1];
	logic [LEN_W-1:0]      len_c;

	assign len_c = LEN_W'(sq_res_s[SQ_STG]);

	always_comb begin
		logic [NUM_W-1:0] r, d;
		logic [Q_W-1:0]   q;
		logic             take;
		int bi;
		for (int i = 0; i < 3; i++) begin
			dv_rem_n[0][i] = (NUM_W'(sq_sd_s[SQ_STG].m[i]) << FRAC) + NUM_W'(len_c >> 1);
			dv_q_n[0][i] = '0;
		end
		for (int k = 1; k <= DIV_STG; k++) begin
			for (int i = 0; i < 3; i++) begin
				r = dv_rem_s[k-1][i];
				q = dv_q_s[k-1][i];
				for (int j = 0; j < DIV_PER; j++) begin
					bi = Q_W - 1 - ((k - 1) * DIV_PER + j);
					if (bi >= 0) begin
						d = NUM_W'(dv_sd_s[k-1].len) << bi;
						take = (r >= d);
						if (take) r = r - d;
						q = {q[Q_W-2:0], take};
					end
				end
				dv_rem_n[k][i] = r;
				dv_q_n[k][i] = q;
			end
		end
	end

	// clamp to 1.0, restore the sign, zero vector gives zeros
	nvout_t           vout_c;
	logic [Q_W-1:0]   qc;
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			qc = (dv_q_s[DIV_STG][i] > Q_ONE) ? Q_ONE : dv_q_s[DIV_STG][i];
			if (dv_sd_s[DIV_STG].zero)
				vout_c[i] = '0;
			else if (dv_sd_s[DIV_STG].neg[i])
				vout_c[i] = NOUT_W'(-{1'b0, qc});
			else
				vout_c[i] = NOUT_W'({1'b0, qc});
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s1  <= mag_c;
			mx_s1   <= mx_c;
			for (int i = 0; i < 3; i++) neg_s1[i] <= vin[i][NIN_W-1];

			mag_s2  <= mag_s1;
			neg_s2  <= neg_s1;
			pos_s2  <= pos_c;
			zero_s2 <= (mx_s1 == '0);

			m_s3    <= m_c;
			neg_s3  <= neg_s2;
			zero_s3 <= zero_s2;

			for (int i = 0; i < 3; i++)
				sq_s4[i] <= (2*M_W)'(m_s3[i]) * (2*M_W)'(m_s3[i]);
			m_s4    <= m_s3;
			neg_s4  <= neg_s3;
			zero_s4 <= zero_s3;

			sq_rem_s[0] <= SQ_W'(sq_s4[0]) + SQ_W'(sq_s4[1]) + SQ_W'(sq_s4[2]);
			sq_res_s[0] <= '0;
			sq_sd_s[0]  <= '{m: m_s4, neg: neg_s4, zero: zero_s4};
			for (int k = 1; k <= SQ_STG; k++) begin
				sq_rem_s[k] <= sq_rem_n[k];
				sq_res_s[k] <= sq_res_n[k];
				sq_sd_s[k]  <= sq_sd_s[k-1];
			end

			dv_rem_s[0] <= dv_rem_n[0];
			dv_q_s[0]   <= dv_q_n[0];
			dv_sd_s[0]  <= '{len: len_c, neg: sq_sd_s[SQ_STG].neg,
				zero: sq_sd_s[SQ_STG].zero};
			for (int k = 1; k <= DIV_STG; k++) begin
				dv_rem_s[k] <= dv_rem_n[k];
				dv_q_s[k]   <= dv_q_n[k];
				dv_sd_s[k]  <= dv_sd_s[k-1];
			end

			vout <= vout_c;
			zero <= dv_sd_s[DIV_STG].zero;
		end
	end

endmodule

>>> sv/look_at_view_matrix.sv
// look_at_view_matrix: fixed-point camera view matrix, four columns per camera transaction
// depends on lav_pkg, lav_if (lav_cam_if, lav_col_if) and lav_norm
//
//   channel  | role   | handshake   | payload
//   ---------+--------+-------------+----------------------------------------------
//   camera   | sink   | valid/ready | eye, target, up (x, y, z), signed Q16.16
//   column   | source | valid/ready | column_index, entry_row0..3, last_column,
//            |        |             | degenerate, saturated
//
// the column output register hands out four columns per transaction and holds every
// stage until the last is taken; new camera transactions enter while earlier ones are
// still in the pipe
// reset clears only valid bits and the column counter; no clearing pass
// one global advance signal: while the last column waits, every stage holds
module look_at_view_matrix (
	input logic      clk,
	input logic      arst_n,
	lav_cam_if.sink  camera,
	lav_col_if.source column
);
	import lav_pkg::*;

	localparam int DIFF_W = EYE_W + 1;
	localparam int CP_W   = 2 * NOUT_W;      // cross product terms
	localparam int U_W    = 20;              // true-up components
	localparam int DP_W   = U_W + EYE_W;     // dot product terms
	localparam int DS_W   = DP_W + 2;        // dot product sums
	localparam int DR_W   = DS_W - FRAC;     // rounded dot magnitudes
	localparam int TOTAL  = 2 * NORM_LAT + 8;

	localparam logic [DS_W-1:0] HALF_D  = DS_W'(32768);
	localparam logic [NIN_W-1:0] HALF_U = NIN_W'(32768);
	localparam logic [DR_W-1:0] LIM_NEG = DR_W'(64'd2147483648);
	localparam logic [DR_W-1:0] LIM_POS = DR_W'(64'd2147483647);

	typedef struct packed {
		eye3_t  eye;
		nvout_t f;
		logic   dg;
	} side_t;

	typedef struct packed {
		nvout_t s;
		nvout_t f;
		logic   dg;
	} tail_t;

	// global advance: the whole pipe moves unless the final column is still waiting
	logic            adv;
	logic [TOTAL-1:0] vld_s;
	logic            busy_q;
	logic [1:0]      col_q;

	assign adv = !busy_q || (column.ready && col_q == LAST_COL);
	assign camera.ready = adv;

	// stage 1: forward difference, up and eye captured
	eye3_t eye_c, tgt_c, up_c;
	assign eye_c = {camera.eye_z, camera.eye_y, camera.eye_x};
	assign tgt_c = {camera.target_z, camera.target_y, camera.target_x};
	assign up_c  = {camera.up_z, camera.up_y, camera.up_x};

	eye3_t eye_s1;
	nvin_t diff_s1, up_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			eye_s1 <= eye_c;
			for (int i = 0; i < 3; i++) begin
				diff_s1[i] <= NIN_W'($signed({tgt_c[i][EYE_W-1], tgt_c[i]})
					- $signed({eye_c[i][EYE_W-1], eye_c[i]}));
				up_s1[i] <= NIN_W'($signed(up_c[i]));
			end
		end
	end

	// forward and up normalized side by side
	nvout_t f_n, n_n;
	logic   f_zero, n_zero;

	lav_norm u_norm_f (.clk(clk), .en(adv), .vin(diff_s1), .vout(f_n), .zero(f_zero));
	lav_norm u_norm_n (.clk(clk), .en(adv), .vin(up_s1), .vout(n_n), .zero(n_zero));

	// eye rides along the first normalizer
	eye3_t eye_dly_q [NORM_LAT];
	always_ff @(posedge clk) begin
		if (adv) begin
			eye_dly_q[0] <= eye_s1;
			for (int k = 1; k < NORM_LAT; k++) eye_dly_q[k] <= eye_dly_q[k-1];
		end
	end

	// stages 2 and 3: raw side vector f x n at Q4.32
	logic signed [CP_W-1:0]  xp_s2 [6];
	nvin_t                   cr_s3;
	side_t                   sd_s2, sd_s3;

	always_ff @(posedge clk) begin
		if (adv) begin
			xp_s2[0] <= $signed(f_n[1]) * $signed(n_n[2]);
			xp_s2[1] <= $signed(f_n[2]) * $signed(n_n[1]);
			xp_s2[2] <= $signed(f_n[2]) * $signed(n_n[0]);
			xp_s2[3] <= $signed(f_n[0]) * $signed(n_n[2]);
			xp_s2[4] <= $signed(f_n[0]) * $signed(n_n[1]);
			xp_s2[5] <= $signed(f_n[1]) * $signed(n_n[0]);
			sd_s2 <= '{eye: eye_dly_q[NORM_LAT-1], f: f_n, dg: f_zero | n_zero};

			for (int i = 0; i < 3; i++) cr_s3[i] <= xp_s2[2*i] - xp_s2[2*i+1];
			sd_s3 <= sd_s2;
		end
	end

	// side vector normalized
	nvout_t s_n;
	logic   s_zero;

	lav_norm u_norm_s (.clk(clk), .en(adv), .vin(cr_s3), .vout(s_n), .zero(s_zero));

	side_t sd_dly_q [NORM_LAT];
	always_ff @(posedge clk) begin
		if (adv) begin
			sd_dly_q[0] <= sd_s3;
			for (int k = 1; k < NORM_LAT; k++) sd_dly_q[k] <= sd_dly_q[k-1];
		end
	end

	// stages 4 to 6: true up u = s x f, rounded back to Q4.16
	logic signed [CP_W-1:0]  up_p_s4 [6];
	logic signed [NIN_W-1:0] cu_s5 [3];
	logic [2:0][U_W-1:0]     u_s6, u_s7, u_s8;
	eye3_t                   eye_s4, eye_s5, eye_s6;
	tail_t                   tl_s4, tl_s5, tl_s6, tl_s7, tl_s8;
	logic [2:0][U_W-1:0]     u_c;
	logic [NIN_W-1:0]        um;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			um = cu_s5[i][NIN_W-1] ? (~cu_s5[i] + 1'b1) : cu_s5[i];
			um = (um + HALF_U) >> FRAC;
			u_c[i] = cu_s5[i][NIN_W-1] ? U_W'(-um) : U_W'(um);
		end
	end

	// stages 7 and 8: dot products with eye, summed exactly
	logic signed [DP_W-1:0] dp_s7 [3][3];
	logic signed [DS_W-1:0] ds_s8 [3];

	always_ff @(posedge clk) begin
		if (adv) begin
			up_p_s4[0] <= $signed(s_n[1]) * $signed(sd_dly_q[NORM_LAT-1].f[2]);
			up_p_s4[1] <= $signed(s_n[2]) * $signed(sd_dly_q[NORM_LAT-1].f[1]);
			up_p_s4[2] <= $signed(s_n[2]) * $signed(sd_dly_q[NORM_LAT-1].f[0]);
			up_p_s4[3] <= $signed(s_n[0]) * $signed(sd_dly_q[NORM_LAT-1].f[2]);
			up_p_s4[4] <= $signed(s_n[0]) * $signed(sd_dly_q[NORM_LAT-1].f[1]);
			up_p_s4[5] <= $signed(s_n[1]) * $signed(sd_dly_q[NORM_LAT-1].f[0]);
			eye_s4 <= sd_dly_q[NORM_LAT-1].eye;
			tl_s4  <= '{s: s_n, f: sd_dly_q[NORM_LAT-1].f,
				dg: sd_dly_q[NORM_LAT-1].dg | s_zero};

			for (int i = 0; i < 3; i++) cu_s5[i] <= up_p_s4[2*i] - up_p_s4[2*i+1];
			eye_s5 <= eye_s4;
			tl_s5  <= tl_s4;

			u_s6   <= u_c;
			eye_s6 <= eye_s5;
			tl_s6  <= tl_s5;

			for (int i = 0; i < 3; i++) begin
				dp_s7[0][i] <= $signed(tl_s6.s[i]) * $signed(eye_s6[i]);
				dp_s7[1][i] <= $signed(u_s6[i]) * $signed(eye_s6[i]);
				dp_s7[2][i] <= $signed(tl_s6.f[i]) * $signed(eye_s6[i]);
			end
			u_s7  <= u_s6;
			tl_s7 <= tl_s6;

			for (int a = 0; a < 3; a++)
				ds_s8[a] <= DS_W'(dp_s7[a][0]) + DS_W'(dp_s7[a][1]) + DS_W'(dp_s7[a][2]);
			u_s8  <= u_s7;
			tl_s8 <= tl_s7;
		end
	end

	// translation: round, negate for s and u rows, clamp to 32 bits
	eye3_t           t_c;
	logic [2:0]      sat_c;
	logic [DS_W-1:0] xm;
	logic [DR_W-1:0] rr;
	logic            neg_out;

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			xm = ds_s8[a][DS_W-1] ? (~ds_s8[a] + 1'b1) : ds_s8[a];
			rr = DR_W'((xm + HALF_D) >> FRAC);
			neg_out = ds_s8[a][DS_W-1] ^ (a != 2);
			sat_c[a] = 1'b0;
			if (neg_out) begin
				if (rr > LIM_NEG) begin
					t_c[a] = 32'h8000_0000;
					sat_c[a] = 1'b1;
				end else begin
					t_c[a] = EYE_W'(~rr + 1'b1);
				end
			end else begin
				if (rr > LIM_POS) begin
					t_c[a] = 32'h7fff_ffff;
					sat_c[a] = 1'b1;
				end else begin
					t_c[a] = EYE_W'(rr);
				end
			end
		end
	end

	// stage 9: the column output register, one matrix at a time
	nvout_t              s_s9, f_s9;
	logic [2:0][U_W-1:0] u_s9;
	eye3_t               t_s9;
	logic                dg_s9, sat_s9;

	always_ff @(posedge clk) begin
		if (adv) begin
			s_s9   <= tl_s8.s;
			f_s9   <= tl_s8.f;
			u_s9   <= u_s8;
			t_s9   <= t_c;
			dg_s9  <= tl_s8.dg;
			sat_s9 <= |sat_c;
		end
	end

	// valid bits travel with the data; counter walks the four columns
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s  <= '0;
			busy_q <= 1'b0;
			col_q  <= '0;
		end else begin
			if (adv) begin
				vld_s  <= {vld_s[TOTAL-2:0], camera.valid};
				busy_q <= vld_s[TOTAL-1];
				col_q  <= '0;
			end else if (column.ready) begin
				col_q <= col_q + 2'd1;
			end
		end
	end

	assign column.valid        = busy_q;
	assign column.column_index = col_q;
	assign column.last_column  = (col_q == LAST_COL);
	assign column.degenerate   = dg_s9;
	assign column.saturated    = sat_s9;

	// rotation columns hold s, u, -f and 0; the last holds the translation and 1
	always_comb begin
		if (col_q == LAST_COL) begin
			column.entry_row0 = $signed(t_s9[0]);
			column.entry_row1 = $signed(t_s9[1]);
			column.entry_row2 = $signed(t_s9[2]);
			column.entry_row3 = ONE_Q16;
		end else begin
			column.entry_row0 = EYE_W'($signed(s_s9[col_q]));
			column.entry_row1 = EYE_W'($signed(u_s9[col_q]));
			column.entry_row2 = EYE_W'(-$signed(f_s9[col_q]));
			column.entry_row3 = '0;
		end
	end

	// columns are handed out in order
	a_col_order: assert property (@(posedge clk) disable iff (!arst_n)
		column.valid && column.ready && column.column_index != LAST_COL
		|=> column.valid && column.column_index == $past(column.column_index) + 2'd1)
		else $error("column order broken");

	// flags are the same on all four columns of one matrix
	a_flags_hold: assert property (@(posedge clk) disable iff (!arst_n)
		column.valid && column.ready && !column.last_column
		|=> $stable(column.degenerate) && $stable(column.saturated))
		else $error("flags changed within a matrix");

	// a stalled pipe keeps its valid bits
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> vld_s == $past(vld_s))
		else $error("valid bits moved during a stall");

	// a new matrix is loaded only after the last column has gone
	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && !(column.ready && col_q == LAST_COL) |=> busy_q && $stable(t_s9))
		else $error("pending matrix overwritten");

endmodule

>>> dv/lav_checker.sv
// lav_checker: watches the camera and column channels, predicts each matrix column
// depends on lav_if (lav_cam_if, lav_col_if); reports mismatch and pending counts to the bench top
`timescale 1ns / 1ps
module lav_checker (
	input  logic clk,
	input  logic arst_n,
	lav_cam_if   camera,
	lav_col_if   column,
	output int   errors,
	output int   pending
);

	typedef longint vec3_t [3];

	typedef struct {
		logic [1:0]         column_index;
		logic signed [31:0] entry_row0;
		logic signed [31:0] entry_row1;
		logic signed [31:0] entry_row2;
		logic signed [31:0] entry_row3;
		logic               last_column;
		logic               degenerate;
		logic               saturated;
	} column_t;

	column_t expected_cols[$];

	function automatic longint unsigned root_floor(input longint unsigned n);
		longint unsigned res, bitv, rem;
		res  = 0;
		rem  = n;
		bitv = 64'd1 << 62;
		while (bitv > rem)
			bitv = bitv >> 2;
		while (bitv != 0) begin
			if (rem >= res + bitv) begin
				rem = rem - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res;
	endfunction

	function automatic longint round_to_q16(input longint x);
		longint unsigned m;
		m = ((x < 0 ? -x : x) + 64'd32768) >> 16;
		return x < 0 ? -longint'(m) : longint'(m);
	endfunction

	// unit vector in Q16.16; zero flag on a null input
	function automatic void unit_vec(input vec3_t v, output vec3_t o, output bit zero);
		longint unsigned m[3];
		longint unsigned mx, sum, len, q;
		mx = 0;
		sum = 0;
		for (int i = 0; i < 3; i++) begin
			m[i] = v[i] < 0 ? -v[i] : v[i];
			if (m[i] > mx)
				mx = m[i];
		end
		zero = (mx == 0);
		for (int i = 0; i < 3; i++)
			o[i] = 0;
		if (!zero) begin
			while (mx < (64'd1 << 29)) begin
				mx = mx << 1;
				for (int i = 0; i < 3; i++)
					m[i] = m[i] << 1;
			end
			while (mx >= (64'd1 << 30)) begin
				mx = mx >> 1;
				for (int i = 0; i < 3; i++)
					m[i] = m[i] >> 1;
			end
			for (int i = 0; i < 3; i++)
				sum = sum + m[i] * m[i];
			len = root_floor(sum);
			for (int i = 0; i < 3; i++) begin
				q = (m[i] * 64'd65536 + (len >> 1)) / len;
				if (q > 65536)
					q = 65536;
				o[i] = v[i] < 0 ? -longint'(q) : longint'(q);
			end
		end
	endfunction

	function automatic void cross_exact(input vec3_t a, input vec3_t b, output vec3_t r);
		r[0] = a[1] * b[2] - a[2] * b[1];
		r[1] = a[2] * b[0] - a[0] * b[2];
		r[2] = a[0] * b[1] - a[1] * b[0];
	endfunction

	function automatic longint translate(input vec3_t a, input vec3_t e, input bit neg,
		inout bit sat);
		longint d;
		d = round_to_q16(a[0] * e[0] + a[1] * e[1] + a[2] * e[2]);
		if (neg)
			d = -d;
		if (d > 64'sd2147483647) begin
			sat = 1;
			d = 64'sd2147483647;
		end else if (d < -64'sd2147483648) begin
			sat = 1;
			d = -64'sd2147483648;
		end
		return d;
	endfunction

	task automatic predict_view_matrix();
		vec3_t eye, dir, upv, f, n, c, s, u;
		longint t[3];
		bit z, degen, sat;
		column_t col;
		eye[0] = camera.eye_x;
		eye[1] = camera.eye_y;
		eye[2] = camera.eye_z;
		dir[0] = longint'(camera.target_x) - eye[0];
		dir[1] = longint'(camera.target_y) - eye[1];
		dir[2] = longint'(camera.target_z) - eye[2];
		upv[0] = camera.up_x;
		upv[1] = camera.up_y;
		upv[2] = camera.up_z;
		degen = 0;
		sat = 0;
		unit_vec(dir, f, z);
		degen |= z;
		unit_vec(upv, n, z);
		degen |= z;
		cross_exact(f, n, c);
		unit_vec(c, s, z);
		degen |= z;
		cross_exact(s, f, c);
		for (int i = 0; i < 3; i++)
			u[i] = round_to_q16(c[i]);
		t[0] = translate(s, eye, 1, sat);
		t[1] = translate(u, eye, 1, sat);
		t[2] = translate(f, eye, 0, sat);
		for (int k = 0; k < 4; k++) begin
			col.column_index = k[1:0];
			col.entry_row0   = k < 3 ? s[k][31:0]    : t[0][31:0];
			col.entry_row1   = k < 3 ? u[k][31:0]    : t[1][31:0];
			col.entry_row2   = k < 3 ? 32'(-f[k])    : t[2][31:0];
			col.entry_row3   = k < 3 ? 32'sd0        : 32'sd65536;
			col.last_column  = (k == 3);
			col.degenerate   = degen;
			col.saturated    = sat;
			expected_cols.push_back(col);
		end
	endtask

	task automatic flag_mismatch(input string what, input column_t exp);
		errors++;
		if (errors <= 10)
			$display({"mismatch %s: exp col %0d %h %h %h %h l%b d%b s%b,",
				" got col %0d %h %h %h %h l%b d%b s%b"},
				what, exp.column_index, exp.entry_row0, exp.entry_row1, exp.entry_row2,
				exp.entry_row3, exp.last_column, exp.degenerate, exp.saturated,
				column.column_index, column.entry_row0, column.entry_row1,
				column.entry_row2, column.entry_row3, column.last_column,
				column.degenerate, column.saturated);
	endtask

	initial errors = 0;

	always @(posedge clk) begin
		column_t exp;
		if (arst_n) begin
			if (camera.valid && camera.ready)
				predict_view_matrix();
			if (column.valid && column.ready) begin
				if (expected_cols.size() == 0) begin
					exp = '{default: '0};
					flag_mismatch("unexpected transaction", exp);
				end else begin
					exp = expected_cols.pop_front();
					if (column.column_index !== exp.column_index
						|| column.entry_row0 !== exp.entry_row0
						|| column.entry_row1 !== exp.entry_row1
						|| column.entry_row2 !== exp.entry_row2
						|| column.entry_row3 !== exp.entry_row3
						|| column.last_column !== exp.last_column
						|| column.degenerate !== exp.degenerate
						|| column.saturated !== exp.saturated)
						flag_mismatch("field", exp);
				end
			end
		end
		pending <= expected_cols.size();
	end

endmodule

>>> dv/tb_look_at_view_matrix.sv
// tb_look_at_view_matrix: stimulus and verdict for the look-at view matrix block
// depends on lav_pkg, lav_if, look_at_view_matrix and lav_checker
`timescale 1ns / 1ps
module tb_look_at_view_matrix;
	import lav_pkg::*;

	localparam int  N_RANDOM   = 230;
	localparam int  LIMIT      = 500000;    // cycles, far above the slowest correct run
	localparam int  DRAIN      = 200;       // well past the pipeline latency
	localparam int  HOLD_LEN   = 400;       // long receiver hold-off to fill the pipeline

	// idle profiles: no idling, sender idles, receiver stalls, both
	typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

	logic clk = 0;
	logic arst_n = 0;
	int errors, pending;
	int cycles = 0;
	idle_mode_t mode = IDLE_NONE;
	bit hold_req = 0;
	bit hold_done = 0;
	int hold_left = 0;

	lav_cam_if camera();
	lav_col_if column();

	look_at_view_matrix DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.camera (camera),
		.column (column)
	);

	lav_checker checker_i (
		.clk     (clk),
		.arst_n  (arst_n),
		.camera  (camera),
		.column  (column),
		.errors  (errors),
		.pending (pending)
	);

	always #6 clk = ~clk;

	// watchdog on total run length
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// one long hold-off, counted down in its own process
	always @(negedge clk) begin
		if (hold_req && !hold_done && arst_n) begin
			hold_left <= HOLD_LEN;
			hold_done <= 1;
		end else if (hold_left > 0)
			hold_left <= hold_left - 1;
	end

	// column receiver: random stalls per mode, held off while the hold-off runs
	initial column.ready = 0;
	always @(negedge clk) begin
		if (hold_left > 0 || (hold_req && !hold_done))
			column.ready <= 0;
		else if (mode == IDLE_RECV)
			column.ready <= ($urandom_range(99) >= 57);
		else if (mode == IDLE_BOTH)
			column.ready <= ($urandom_range(99) >= 8);
		else
			column.ready <= 1;
	end

	// one camera transaction: idle cycles per mode, then hold until accepted
	task automatic send_camera(input logic [31:0] ex, ey, ez, tx, ty, tz, ux, uy, uz);
		int gap_pct;
		gap_pct = (mode == IDLE_SEND) ? 57 : (mode == IDLE_BOTH) ? 8 : 0;
		while ($urandom_range(99) < gap_pct) begin
			camera.valid <= 0;
			@(negedge clk);
		end
		camera.valid    <= 1;
		camera.eye_x    <= ex;
		camera.eye_y    <= ey;
		camera.eye_z    <= ez;
		camera.target_x <= tx;
		camera.target_y <= ty;
		camera.target_z <= tz;
		camera.up_x     <= ux;
		camera.up_y     <= uy;
		camera.up_z     <= uz;
		do @(posedge clk); while (!camera.ready);
		@(negedge clk);
	endtask

	// random camera: mostly real scenes at a random scale, some raw noise and edge cases
	task automatic send_random();
		logic [31:0] e[3], t[3], u[3];
		int kind, sh;
		kind = $urandom_range(99);
		sh = $urandom_range(24);
		for (int i = 0; i < 3; i++) begin
			e[i] = $signed($urandom) >>> sh;
			t[i] = $signed($urandom) >>> sh;
			u[i] = $signed($urandom) >>> $urandom_range(28);
		end
		if (kind < 25) begin
			for (int i = 0; i < 3; i++) begin
				e[i] = $urandom;
				t[i] = $urandom;
				u[i] = $urandom;
			end
		end else if (kind < 33) begin
			t = e;                                  // target on the eye
		end else if (kind < 40) begin
			u = '{32'd0, 32'd0, 32'd0};             // null up vector
		end else if (kind < 48) begin
			for (int i = 0; i < 3; i++)             // up along the view direction
				u[i] = (($signed(t[i]) >>> 1) - ($signed(e[i]) >>> 1))
					* $urandom_range(3, 1);
		end
		send_camera(e[0], e[1], e[2], t[0], t[1], t[2], u[0], u[1], u[2]);
	endtask

	localparam logic [31:0] MAXV = 32'h7fff_ffff;
	localparam logic [31:0] MINV = 32'h8000_0000;
	localparam logic [31:0] ONE  = 32'h0001_0000;
	localparam logic [31:0] NEG1 = 32'hffff_0000;

	initial begin
		camera.valid = 0;
		{camera.eye_x, camera.eye_y, camera.eye_z} = '0;
		{camera.target_x, camera.target_y, camera.target_z} = '0;
		{camera.up_x, camera.up_y, camera.up_z} = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// directed: plain scene, degenerate inputs, extremes and clamped translation
		send_camera(0, 0, 5 * ONE, 0, 0, 0, 0, ONE, 0);
		send_camera(ONE, 2 * ONE, 3 * ONE, ONE, 2 * ONE, 3 * ONE, 0, ONE, 0);
		send_camera(0, 0, 0, ONE, 0, 0, 0, 0, 0);
		send_camera(0, 0, 0, 0, ONE, 0, 0, 3 * ONE, 0);
		send_camera(0, 0, 0, 0, 0, 0, 0, 0, 0);
		send_camera(MAXV, MAXV, MAXV, MINV, MINV, MINV, 0, ONE, 0);
		send_camera(MINV, MINV, MINV, MAXV, MAXV, MAXV, ONE, 0, 0);
		send_camera(MAXV, MINV, MAXV, MINV, MAXV, MINV, MAXV, MAXV, MINV);
		send_camera(MINV, 0, MAXV, 0, 0, 0, MINV, MINV, MINV);
		send_camera(MAXV, 0, 0, MAXV, 1, 0, 0, 0, 1);
		send_camera(0, 0, 0, 1, 0, 0, 0, 1, 0);
		send_camera(32'hffff_ffff, 0, 0, 0, 0, 0, 0, NEG1, 0);
		send_camera(MAXV, MAXV, 0, 0, 0, MAXV, 0, 0, MAXV);
		send_camera(0, 0, 0, MAXV, MAXV, MAXV, MINV, 32'h5555_5555, 32'haaaa_aaaa);
		send_camera(32'haaaa_aaaa, 32'h5555_5555, 32'hffff_ffff, 32'h5555_5555,
			32'haaaa_aaaa, 0, 32'hffff_ffff, 32'h0000_0001, 32'h8000_0001);

		// random part across the idle profiles; the long hold-off opens the stalling phase
		for (int i = 0; i < N_RANDOM; i++) begin
			mode = idle_mode_t'(i * 4 / N_RANDOM);
			if (i == N_RANDOM / 2)
				hold_req = 1;
			send_random();
		end
		camera.valid <= 0;

		while (pending != 0 || hold_left != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
